[rtl/core/gfba_pkg.sv]
// Package for the grouped free-block allocator: word types, command and
// status structs between controller and datapath, and shared constants.
// Depends on nothing.
package gfba_pkg;

    localparam int GROUP_SIZE_DEF = 32;
    localparam int NBLOCKS_DEF    = 1024;
    localparam int BLOCK_W        = 10;
    localparam int FREE_W         = 11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [BLOCK_W-1:0] block_number;
    } gfba_req_t;

    typedef struct packed {
        logic               ok;
        logic [BLOCK_W-1:0] granted_block;
        logic [FREE_W-1:0]  free_total;
    } gfba_rsp_t;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic refill;
        logic spill;
        logic deliver;
    } gfba_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic item_alloc;
        logic stack_full;
        logic top_zero;
        logic copy_end;
    } gfba_status_t;

endpackage

[rtl/core/gfba_ctrl.sv]
// Controller state machine of the grouped free-block allocator.
// Depends on gfba_pkg; drives the datapath through gfba_cmd_t.
module gfba_ctrl
    import gfba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    input  gfba_status_t status,
    output gfba_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_REFILL,
        S_SPILL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.item_ok)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (status.item_alloc)
                    begin
                        state_next = S_POP;
                    end
                    else if (status.stack_full)
                    begin
                        state_next = S_SPILL;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_FINISH;
                    end
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = status.top_zero ? S_REFILL : S_FINISH;
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
                if (status.copy_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SPILL:
            begin
                cmd.spill = 1'b1;
                if (status.copy_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.deliver    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[rtl/core/gfba_datapath.sv]
// Datapath of the grouped free-block allocator: in-core stack memory, link
// row memory, fill count, free total, copy counter and result register.
// Depends on gfba_pkg; commanded by gfba_ctrl.
module gfba_datapath
    import gfba_pkg::*;
#(
    parameter int GROUP_SIZE = GROUP_SIZE_DEF,
    parameter int NBLOCKS    = NBLOCKS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  gfba_cmd_t    cmd,
    input  gfba_req_t    req,
    output gfba_status_t status,
    output gfba_rsp_t    rsp
);

    localparam int IDX_W      = $clog2(GROUP_SIZE);
    localparam int CNT_W      = $clog2(GROUP_SIZE + 1);
    localparam int TOT_W      = $clog2(NBLOCKS + 1);
    localparam int LNK_A_W    = BLOCK_W + IDX_W;
    localparam int LINK_DEPTH = 1 << LNK_A_W;

    logic [BLOCK_W-1:0] stack_mem [GROUP_SIZE];
    logic [BLOCK_W-1:0] link_mem  [LINK_DEPTH];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   cp_reg, cp_next;

    logic [BLOCK_W-1:0] stk_rd_reg;
    logic [BLOCK_W-1:0] lnk_rd_reg;
    logic               ok_reg;
    logic [BLOCK_W-1:0] gr_reg;
    logic [BLOCK_W-1:0] blk_reg;
    gfba_rsp_t          rsp_reg;

    logic [CNT_W-1:0]         top_cnt;
    logic [CNT_W-1:0]         cp_dec;
    logic [IDX_W-1:0]         cp_idx;
    logic [IDX_W-1:0]         cp_dec_idx;
    logic                     cp_zero;
    logic                     total_zero;
    logic                     total_full;
    logic [IDX_W-1:0]         stk_ra;
    logic                     stk_we;
    logic [IDX_W-1:0]         stk_wa;
    logic [BLOCK_W-1:0]       stk_wd;
    logic                     lnk_we;
    logic [LNK_A_W-1:0]       lnk_ra;
    logic [LNK_A_W-1:0]       lnk_wa;
    logic [TOT_W+FREE_W-1:0]  total_wide;

    assign top_cnt    = (count_reg == '0) ? '0 : count_reg - CNT_W'(1);
    assign cp_dec     = cp_reg - CNT_W'(1);
    assign cp_zero    = (cp_reg == '0);
    assign cp_dec_idx = cp_dec[IDX_W-1:0];
    assign cp_idx     = status.copy_end ? '0 : cp_reg[IDX_W-1:0];
    assign total_zero = (total_reg == '0);
    assign total_full = (total_reg >= TOT_W'(NBLOCKS));

    assign status.item_ok    = (req.operation == OP_FREE) ? !total_full : !total_zero;
    assign status.item_alloc = (req.operation == OP_ALLOC);
    assign status.stack_full = (count_reg >= CNT_W'(GROUP_SIZE));
    assign status.top_zero   = (count_reg <= CNT_W'(1));
    assign status.copy_end   = (cp_reg == CNT_W'(GROUP_SIZE));

    // Stack read port: the top entry unless spilling, the copy index while spilling.
    assign stk_ra = cmd.spill ? cp_idx : top_cnt[IDX_W-1:0];

    always_comb
    begin
        stk_we = 1'b0;
        stk_wa = '0;
        stk_wd = req.block_number;
        if (cmd.push)
        begin
            stk_we = 1'b1;
            stk_wa = count_reg[IDX_W-1:0];
        end
        else if (cmd.refill && !cp_zero)
        begin
            stk_we = 1'b1;
            stk_wa = cp_dec_idx;
            stk_wd = lnk_rd_reg;
        end
        else if (cmd.spill && status.copy_end)
        begin
            stk_we = 1'b1;
            stk_wd = blk_reg;
        end
    end

    assign lnk_ra = {gr_reg, cp_idx};
    assign lnk_wa = {blk_reg, cp_dec_idx};
    assign lnk_we = cmd.spill && !cp_zero;

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        cp_next    = cp_reg;
        if (cmd.load)
        begin
            cp_next = '0;
        end
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            total_next = total_reg + TOT_W'(1);
        end
        if (cmd.pop)
        begin
            count_next = top_cnt;
            total_next = total_reg - TOT_W'(1);
            cp_next    = '0;
        end
        if (cmd.refill || cmd.spill)
        begin
            cp_next = cp_reg + CNT_W'(1);
            if (status.copy_end)
            begin
                if (cmd.refill)
                begin
                    count_next = CNT_W'(GROUP_SIZE);
                end
                else
                begin
                    count_next = CNT_W'(1);
                    total_next = total_reg + TOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            cp_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
            cp_reg    <= cp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        stk_rd_reg <= stack_mem[stk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            link_mem[lnk_wa] <= stk_rd_reg;
        end
        lnk_rd_reg <= link_mem[lnk_ra];
    end

    assign total_wide = (TOT_W + FREE_W)'(total_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg  <= status.item_ok;
            gr_reg  <= '0;
            blk_reg <= req.block_number;
        end
        if (cmd.pop)
        begin
            gr_reg <= stk_rd_reg;
        end
        if (cmd.deliver)
        begin
            rsp_reg.ok            <= ok_reg;
            rsp_reg.granted_block <= gr_reg;
            rsp_reg.free_total    <= total_wide[FREE_W-1:0];
        end
    end

    assign rsp = rsp_reg;

endmodule

[rtl/core/grouped_free_block_allocator.sv]
// Top level of the grouped free-block allocator: joins controller and datapath.
// Depends on gfba_pkg, gfba_ctrl and gfba_datapath.
//
//   Channel  Handshake              Word        Direction
//   req      req_valid / req_ready  gfba_req_t  into the block
//   rsp      rsp_valid / rsp_ready  gfba_rsp_t  out of the block
//
// A free that needs no spill, and any refused word, goes from idle straight to
// finish. An allocation passes through the pop state, as the top of the stack
// comes from a memory read that is registered. A refill or a spill copies one
// stack entry a cycle through a read port and a write port of each memory.
// The result register lets the next word be accepted while the last result
// waits; a finished word holds only if that register is still occupied.
// Reset clears the fill count, the free total and the copy counter alone; the
// link rows need no clearing pass, as the total guards every read of them.
module grouped_free_block_allocator
    import gfba_pkg::*;
#(
    parameter int GROUP_SIZE = GROUP_SIZE_DEF,
    parameter int NBLOCKS    = NBLOCKS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  gfba_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output gfba_rsp_t rsp
);

    // Command and status are the only coupling between the two halves.
    gfba_cmd_t    cmd;
    gfba_status_t status;

    // The controller sequences each word: accept, pop, copy and deliver.
    gfba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the stack, the link rows and the counters.
    gfba_datapath #(
        .GROUP_SIZE (GROUP_SIZE),
        .NBLOCKS    (NBLOCKS)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .rsp    (rsp)
    );

endmodule

[rtl/core/gfba_checker.sv]
// Port-level checker for the grouped free-block allocator, bound to the top.
// Depends on gfba_pkg and grouped_free_block_allocator.
module gfba_checker
    import gfba_pkg::*;
#(
    parameter int NBLOCKS = NBLOCKS_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input gfba_req_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input gfba_rsp_t rsp
);

    a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("stalled result word changed");

    a_refused_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.granted_block == '0)
        else $error("refused word carries a granted block");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.free_total <= NBLOCKS)
        else $error("free total beyond the number of blocks");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word accepted while one is at work");

endmodule

bind grouped_free_block_allocator gfba_checker #(.NBLOCKS(NBLOCKS)) u_gfba_checker (.*);

[tb/grouped_free_block_allocator_test.sv]
// Self-checking test of the grouped free-block allocator: random request and
// result traffic, checked word by word against an in-bench free-list predictor.
// Depends on gfba_pkg and grouped_free_block_allocator.
module grouped_free_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gfba_pkg::*;

    localparam int GROUP     = GROUP_SIZE_DEF;
    localparam int NBLK      = NBLOCKS_DEF;
    localparam int FILL_LEN  = 160;
    localparam int WALK_LEN  = 120;

    // A queued request word, with a flag that holds it back until every
    // earlier word has produced its result.
    typedef struct packed {
        gfba_req_t word;
        logic      settle;
    } queued_word_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    gfba_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    gfba_rsp_t rsp;

    grouped_free_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Stimulus side.
    queued_word_t pending[$];
    int           words_queued = 0;
    int           words_sent   = 0;
    int           send_gap     = 0;
    int           send_quiet   = 0;

    // Result side and the record of what has been checked.
    gfba_rsp_t    answers_due[$];
    int           results_seen = 0;
    int           take_gap     = 0;
    int           take_quiet   = 0;
    int           mismatches   = 0;

    // Predictor state: the in-core group, its fill count, the free total and
    // the link rows that stand in for the group blocks on disk.
    logic [BLOCK_W-1:0] group_copy [GROUP];
    logic [BLOCK_W-1:0] link_copy  [NBLK][GROUP];
    int                 fill_copy  = 0;
    int                 free_copy  = 0;
    int                 grants     = 0;
    int                 releases   = 0;
    int                 refusals   = 0;
    int                 spills     = 0;
    int                 refills    = 0;

    // Stimulus bookkeeping: the free total the block should hold once every
    // queued word has run, and the blocks already freed since the list was
    // last empty. Freeing each block at most once per such round keeps the
    // chain of link rows intact, so no refill ever reads a row that was never
    // written, except for the final drain, which the total guards.
    int   level_after_queue = 0;
    logic freed_this_round [NBLK];

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Works out the result of one accepted word and advances the predictor.
    function automatic gfba_rsp_t free_list_step(gfba_req_t w);
        gfba_rsp_t a;
        int        top;
        int        i;
        a = '0;
        if (w.operation == OP_ALLOC) begin
            if (free_copy != 0) begin
                top = (fill_copy == 0) ? 0 : fill_copy - 1;
                if (top >= GROUP)
                    top = GROUP - 1;
                a.granted_block = group_copy[top];
                fill_copy = top;
                // Taking the bottom entry empties the group, which is then
                // reloaded from the link row of the block just handed out.
                if (fill_copy == 0) begin
                    for (i = 0; i < GROUP; i++)
                        group_copy[i] = link_copy[a.granted_block][i];
                    fill_copy = GROUP;
                    refills++;
                end
                free_copy--;
                a.ok = 1'b1;
                grants++;
            end
        end else if (free_copy < NBLK) begin
            // A full group is written out into the freed block's link row,
            // and that block becomes the only entry of a fresh group.
            if (fill_copy >= GROUP) begin
                for (i = 0; i < GROUP; i++)
                    link_copy[w.block_number][i] = group_copy[i];
                group_copy[0] = w.block_number;
                fill_copy = 1;
                spills++;
            end else begin
                group_copy[fill_copy] = w.block_number;
                fill_copy++;
            end
            free_copy++;
            a.ok = 1'b1;
            releases++;
        end
        if (!a.ok)
            refusals++;
        a.free_total = FREE_W'(free_copy);
        return a;
    endfunction

    task automatic note_field(input string name, input logic [FREE_W-1:0] want,
                              input logic [FREE_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Adds one word to the stimulus and tracks its effect on the free total.
    task automatic queue_word(input logic op, input logic [BLOCK_W-1:0] blk,
                              input logic settle);
        queued_word_t q;
        q.word.operation    = op;
        q.word.block_number = blk;
        q.settle            = settle;
        pending.push_back(q);
        words_queued++;
        if (op == OP_FREE && level_after_queue < NBLK) begin
            level_after_queue++;
            freed_this_round[blk] = 1'b1;
        end else if (op == OP_ALLOC && level_after_queue != 0) begin
            level_after_queue--;
            if (level_after_queue == 0)
                freed_this_round = '{default: 1'b0};
        end
    endtask

    // Driver: presents the next queued word once the previous one has gone
    // and its trailing gap has run out. A word marked to settle waits until
    // nothing is outstanding; a handshake at this edge still counts as such.
    always @(posedge clk or negedge rst_n)
    begin : send_words
        queued_word_t nxt;
        if (!rst_n) begin
            req_valid  <= 1'b0;
            req        <= '0;
            words_sent <= 0;
            send_gap   <= 0;
            send_quiet <= 0;
        end else begin
            if (req_valid && req_ready)
                words_sent <= words_sent + 1;
            if (!req_valid || req_ready) begin
                if (send_gap != 0) begin
                    req_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end else if (pending.size() != 0 &&
                             (!pending[0].settle ||
                              words_sent + int'(req_valid && req_ready) == results_seen))
                begin
                    nxt = pending.pop_front();
                    req_valid <= 1'b1;
                    req       <= nxt.word;
                    // Now and then a long run of back-to-back words.
                    if (send_quiet != 0) begin
                        send_quiet <= send_quiet - 1;
                    end else begin
                        send_gap <= idle_len();
                        if ($urandom_range(0, 39) == 0)
                            send_quiet <= $urandom_range(40, 120);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on every accepted request word and checks every
    // accepted result word against the oldest prediction. Ready is dropped at
    // random, after results and at other times alike.
    always @(posedge clk or negedge rst_n)
    begin : take_results
        gfba_rsp_t want;
        int        stall;
        if (!rst_n) begin
            rsp_ready    <= 1'b0;
            results_seen <= 0;
            take_gap     <= 0;
            take_quiet   <= 0;
        end else begin
            if (req_valid && req_ready)
                answers_due.push_back(free_list_step(req));
            if (rsp_valid && rsp_ready) begin
                results_seen <= results_seen + 1;
                if (answers_due.size() == 0) begin
                    mismatches++;
                    $error("result word with no request outstanding: %s %0d %0d %0d",
                           "ok, block, total", rsp.ok, rsp.granted_block,
                           rsp.free_total);
                end else begin
                    want = answers_due.pop_front();
                    note_field("ok", FREE_W'(want.ok), FREE_W'(rsp.ok));
                    note_field("granted_block", FREE_W'(want.granted_block),
                               FREE_W'(rsp.granted_block));
                    note_field("free_total", want.free_total, rsp.free_total);
                end
            end
            if (take_gap != 0) begin
                rsp_ready <= 1'b0;
                take_gap  <= take_gap - 1;
            end else if ((rsp_valid && rsp_ready) || $urandom_range(0, 15) == 0) begin
                stall = 0;
                if (take_quiet != 0) begin
                    take_quiet <= take_quiet - 1;
                end else begin
                    stall = idle_len();
                    if ($urandom_range(0, 39) == 0)
                        take_quiet <= $urandom_range(40, 120);
                end
                take_gap  <= stall;
                rsp_ready <= (stall == 0);
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Stimulus, then the wait for the last results and the verdict.
    initial
    begin : run
        logic [BLOCK_W-1:0] order [NBLK];
        logic [BLOCK_W-1:0] blk;
        logic [BLOCK_W-1:0] swap;
        logic               dir;
        int                 target;
        int                 j;
        int                 k;

        freed_this_round = '{default: 1'b0};

        // Directed opening: allocation from an empty list, frees of the end
        // block numbers, a double free popped straight back, the final drain
        // with its refill from a row never written, and the list empty again.
        queue_word(OP_ALLOC, 10'd1023, 1'b0);
        queue_word(OP_FREE,  10'd0,    1'b0);
        queue_word(OP_FREE,  10'd1023, 1'b0);
        queue_word(OP_FREE,  10'd512,  1'b0);
        queue_word(OP_FREE,  10'd341,  1'b0);
        queue_word(OP_FREE,  10'd341,  1'b0);
        queue_word(OP_ALLOC, 10'd0,    1'b0);
        queue_word(OP_ALLOC, 10'd682,  1'b0);
        queue_word(OP_ALLOC, 10'd0,    1'b0);
        queue_word(OP_ALLOC, 10'd1023, 1'b0);
        queue_word(OP_ALLOC, 10'd0,    1'b0);
        queue_word(OP_ALLOC, 10'd0,    1'b0);
        // A free onto the group reloaded by the drain spills it, then the
        // same block is drained once more.
        queue_word(OP_FREE,  10'd1,    1'b0);
        queue_word(OP_ALLOC, 10'd1022, 1'b0);
        queue_word(OP_ALLOC, 10'd1,    1'b0);

        // Free a run of distinct blocks in random order, which crosses the
        // group boundary several times, then drain the list entirely and try twice
        // more to allocate from it.
        for (k = 0; k < NBLK; k++)
            order[k] = BLOCK_W'(k);
        for (k = NBLK - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            swap     = order[k];
            order[k] = order[j];
            order[j] = swap;
        end
        for (k = 0; k < FILL_LEN; k++)
            queue_word(OP_FREE, order[k], k == 0);
        for (k = 0; k < FILL_LEN + 2; k++)
            queue_word(OP_ALLOC, BLOCK_W'($urandom_range(0, NBLK - 1)), 1'b0);

        // Random walk of the free total between random targets, often down to
        // an empty list, with a tenth of the words going against the trend.
        target = 0;
        for (k = 0; k < WALK_LEN; k++) begin
            if (level_after_queue == target)
                target = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 48);
            dir = (level_after_queue < target) ? OP_FREE : OP_ALLOC;
            if ($urandom_range(0, 9) == 0)
                dir = ~dir;
            if (dir == OP_FREE) begin
                blk = BLOCK_W'($urandom_range(0, NBLK - 1));
                while (freed_this_round[blk])
                    blk = blk + 1'b1;
            end else begin
                blk = BLOCK_W'($urandom_range(0, NBLK - 1));
            end
            queue_word(dir, blk, k == 0 || k == WALK_LEN / 2);
        end

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        while (!(pending.size() == 0 && words_sent == words_queued &&
                 results_seen == words_sent))
            @(negedge clk);
        // A further wait lets a late extra result come out, even after a refill.
        repeat (2 * GROUP + 8) @(negedge clk);
        if (answers_due.size() != 0) begin
            mismatches++;
            $error("%0d expected result words never arrived", answers_due.size());
        end

        $display("%0d words checked: %0d allocations, %0d frees, %0d refused",
                 results_seen, grants, releases, refusals);
        $display("group spills %0d, group refills %0d, mismatching fields %0d",
                 spills, refills, mismatches);
        if (mismatches == 0)
            $display("grouped_free_block_allocator_test: clean");
        else
            $display("grouped_free_block_allocator_test: errors");
        $finish;
    end

    // Watchdog, set well beyond the slowest legitimate run.
    initial
    begin : watchdog
        #5000000;
        $display("grouped_free_block_allocator_test: errors");
        $finish;
    end

endmodule
